@@ src/bps_pkg.sv @@
// Shared types, constants and helper functions of the bijective pattern search unit.
package bps_pkg;

	// Sizes of the window, the symbols and the pattern.
	localparam int PatternMax    = 32;
	localparam int SymbolBits    = 4;
	localparam int SymValues     = 1 << SymbolBits;
	localparam int LenWidth      = 6;
	localparam int IdxWidth      = $clog2(PatternMax);
	localparam int CountWidth    = 32;
	localparam int PatternWidth  = PatternMax * SymbolBits;
	localparam int CfgDataWidth  = 64;
	localparam int CfgIndexWidth = 2;
	localparam int MappingWidth  = SymValues * SymbolBits;

	// Depth of the job queue between the front and the back.
	localparam int QueueDepth    = 2;
	localparam int QueuePtrWidth = $clog2(QueueDepth);

	// Configuration register indexes.
	localparam logic [CfgIndexWidth-1:0] CfgPatternLength = 2'd0;
	localparam logic [CfgIndexWidth-1:0] CfgPatternLow    = 2'd1;
	localparam logic [CfgIndexWidth-1:0] CfgPatternHigh   = 2'd2;

	typedef logic [SymbolBits-1:0] sym_t;

	// One input item.
	typedef struct packed {
		logic [3:0] symbol;
		logic       new_source;
	} in_item_t;

	// One result item.
	typedef struct packed {
		logic [31:0] match_start;
		logic [63:0] mapping_packed;
		logic [15:0] mapped_mask;
	} out_item_t;

	// A completed window waiting to be checked.
	typedef struct packed {
		sym_t [PatternMax-1:0]   win;
		logic [LenWidth-1:0]     len;
		logic [CountWidth-1:0]   start;
	} job_t;

	// Push request from the front into the queue.
	typedef struct packed {
		logic valid;
		job_t job;
	} push_t;

	// Length in use: zero acts as one, anything above the window size is clipped.
	function automatic logic [LenWidth-1:0] clamp_len(input logic [LenWidth-1:0] raw);
		logic [LenWidth-1:0] len;
		len = raw;
		if (raw == '0) begin
			len = LenWidth'(1);
		end else if (raw > LenWidth'(PatternMax)) begin
			len = LenWidth'(PatternMax);
		end
		return len;
	endfunction

	// Pattern symbol at a given position of the packed pattern word.
	function automatic sym_t pattern_symbol(input logic [PatternWidth-1:0] pat,
			input logic [IdxWidth-1:0] idx);
		return pat[idx * SymbolBits +: SymbolBits];
	endfunction

endpackage

@@ src/bps_front.sv @@
// Front end: accepts source symbols, keeps the window and position, and queues completed windows.
module bps_front (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          src_valid,
	output logic                          src_ready,
	input  bps_pkg::in_item_t             src_item,
	input  logic [bps_pkg::LenWidth-1:0]  pattern_length,
	input  logic                          queue_full,
	output bps_pkg::push_t                push
);

	bps_pkg::sym_t [bps_pkg::PatternMax-1:0] window_q;
	logic [bps_pkg::CountWidth-1:0]         count_q;

	logic                                   accept;
	logic [bps_pkg::CountWidth-1:0]         count_base;
	logic [bps_pkg::CountWidth-1:0]         count_next;
	logic [bps_pkg::LenWidth-1:0]           len;
	bps_pkg::sym_t [bps_pkg::PatternMax-1:0] window_next;

	// A transfer is taken whenever the queue has room for a possible job.
	assign src_ready = !queue_full;
	assign accept    = src_valid && src_ready;

	// Position count restarts on a new source and saturates at all ones.
	always_comb begin
		count_base = src_item.new_source ? '0 : count_q;
		count_next = (count_base == '1) ? count_base : count_base + 1'b1;
	end

	// Newest symbol enters at the bottom of the window.
	always_comb begin
		window_next = {window_q[bps_pkg::PatternMax-2:0], src_item.symbol};
	end

	assign len = bps_pkg::clamp_len(pattern_length);

	// A window is complete once enough symbols arrived since the last new source.
	always_comb begin
		push.valid     = accept && (count_next >= bps_pkg::CountWidth'(len));
		push.job.win   = window_next;
		push.job.len   = len;
		push.job.start = count_next - bps_pkg::CountWidth'(len);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (accept) begin
			count_q <= count_next;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			window_q <= window_next;
		end
	end

endmodule

@@ src/bps_queue.sv @@
// Short job queue that lets the front and the back stall independently.
module bps_queue (
	input  logic           clk,
	input  logic           arst_n,
	input  bps_pkg::push_t push,
	output logic           full,
	output logic           head_valid,
	output bps_pkg::job_t  head,
	input  logic           pop
);

	bps_pkg::job_t                      entries_q [bps_pkg::QueueDepth];
	logic [bps_pkg::QueuePtrWidth-1:0]  wr_ptr_q;
	logic [bps_pkg::QueuePtrWidth-1:0]  rd_ptr_q;
	logic [bps_pkg::QueuePtrWidth:0]    fill_q;

	logic do_push;
	logic do_pop;

	assign full       = (fill_q == (bps_pkg::QueuePtrWidth+1)'(bps_pkg::QueueDepth));
	assign head_valid = (fill_q != '0);
	assign head       = entries_q[rd_ptr_q];
	assign do_push    = push.valid && !full;
	assign do_pop     = pop && head_valid;

	// Pointer and fill bookkeeping.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (do_push) begin
				wr_ptr_q <= (wr_ptr_q == bps_pkg::QueuePtrWidth'(bps_pkg::QueueDepth - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (do_pop) begin
				rd_ptr_q <= (rd_ptr_q == bps_pkg::QueuePtrWidth'(bps_pkg::QueueDepth - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (do_push && !do_pop) begin
				fill_q <= fill_q + 1'b1;
			end else if (do_pop && !do_push) begin
				fill_q <= fill_q - 1'b1;
			end
		end
	end

	// Job storage.
	always_ff @(posedge clk) begin
		if (do_push) begin
			entries_q[wr_ptr_q] <= push.job;
		end
	end

endmodule

@@ src/bps_back.sv @@
// Back end: walks window and pattern pairs through the two symbol maps and registers the result.
module bps_back (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              head_valid,
	input  bps_pkg::job_t                     head,
	output logic                              pop,
	input  logic [bps_pkg::PatternWidth-1:0]  pattern,
	output logic                              res_valid,
	input  logic                              res_ready,
	output bps_pkg::out_item_t                res_item
);

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_WALK = 3'b010,
		ST_EMIT = 3'b100
	} state_t;

	state_t                         state_q;
	bps_pkg::job_t                  job_q;
	logic [bps_pkg::IdxWidth-1:0]   step_q;
	logic [bps_pkg::SymValues-1:0]  src_set_q;
	logic [bps_pkg::SymValues-1:0]  pat_set_q;
	bps_pkg::sym_t                  fwd_q [bps_pkg::SymValues];
	logic                           res_valid_q;
	bps_pkg::out_item_t             res_item_q;

	logic [bps_pkg::LenWidth-1:0]   win_pos;
	bps_pkg::sym_t                  src_sym;
	bps_pkg::sym_t                  pat_sym;
	logic                           pair_ok;
	logic                           pair_new;
	logic                           last_step;
	logic                           out_free;
	bps_pkg::out_item_t             result;

	assign pop       = (state_q == ST_IDLE) && head_valid;
	assign out_free  = !res_valid_q || res_ready;
	assign res_valid = res_valid_q;
	assign res_item  = res_item_q;

	// Current pair: oldest window symbol goes against pattern symbol zero.
	always_comb begin
		win_pos   = job_q.len - 1'b1 - bps_pkg::LenWidth'(step_q);
		src_sym   = job_q.win[win_pos[bps_pkg::IdxWidth-1:0]];
		pat_sym   = bps_pkg::pattern_symbol(pattern, step_q);
		last_step = (bps_pkg::LenWidth'(step_q) == job_q.len - 1'b1);
	end

	// A mapped source symbol must keep its target; a new one needs a free target.
	always_comb begin
		pair_new = 1'b0;
		if (src_set_q[src_sym]) begin
			pair_ok = (fwd_q[src_sym] == pat_sym);
		end else begin
			pair_ok  = !pat_set_q[pat_sym];
			pair_new = pair_ok;
		end
	end

	// Packed mapping and mask from the final map contents.
	always_comb begin
		result.match_start    = job_q.start;
		result.mapping_packed = '0;
		result.mapped_mask    = src_set_q;
		for (int v = 0; v < bps_pkg::SymValues; v++) begin
			if (src_set_q[v]) begin
				result.mapping_packed[v * bps_pkg::SymbolBits +: bps_pkg::SymbolBits] = fwd_q[v];
			end
		end
	end

	// Sequencer and map valid bits.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			step_q      <= '0;
			src_set_q   <= '0;
			pat_set_q   <= '0;
			res_valid_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (head_valid) begin
						step_q    <= '0;
						src_set_q <= '0;
						pat_set_q <= '0;
						state_q   <= ST_WALK;
					end
				end
				ST_WALK: begin
					if (!pair_ok) begin
						state_q <= ST_IDLE;
					end else begin
						if (pair_new) begin
							src_set_q[src_sym] <= 1'b1;
							pat_set_q[pat_sym] <= 1'b1;
						end
						if (last_step) begin
							state_q <= ST_EMIT;
						end else begin
							step_q <= step_q + 1'b1;
						end
					end
				end
				ST_EMIT: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase

			// Result valid rises when a result is registered and falls once it is taken.
			if (state_q == ST_EMIT && out_free) begin
				res_valid_q <= 1'b1;
			end else if (res_valid_q && res_ready) begin
				res_valid_q <= 1'b0;
			end
		end
	end

	// Job copy, forward map entries and the result register.
	always_ff @(posedge clk) begin
		if (pop) begin
			job_q <= head;
		end
		if (state_q == ST_WALK && pair_new) begin
			fwd_q[src_sym] <= pat_sym;
		end
		if (state_q == ST_EMIT && out_free) begin
			res_item_q <= result;
		end
	end

endmodule

@@ src/bijective_pattern_search_unit.sv @@
// Top level of the bijective pattern search unit: configuration registers and the front, queue and back.
// Source symbols are taken at one per cycle while the two-entry job queue has room. Each completed
// window is checked by the back end in order: a setup step that clears the symbol maps, a walk of
// the window and pattern pairs through the forward and reverse symbol maps, which sets the check
// time, and a step that registers the result; a mismatch ends the walk at the first conflicting
// pair. The back end takes a new window only once it is through with the last one. Configuration
// writes are always taken and must only be issued while the block is idle.
module bijective_pattern_search_unit (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               src_valid,
	output logic                               src_ready,
	input  bps_pkg::in_item_t                  src_item,
	output logic                               res_valid,
	input  logic                               res_ready,
	output bps_pkg::out_item_t                 res_item,
	input  logic                               cfg_valid,
	output logic                               cfg_ready,
	input  logic [bps_pkg::CfgIndexWidth-1:0]  cfg_index,
	input  logic [bps_pkg::CfgDataWidth-1:0]   cfg_data
);

	logic [bps_pkg::LenWidth-1:0]     pattern_length_q;
	logic [bps_pkg::CfgDataWidth-1:0] pattern_low_q;
	logic [bps_pkg::CfgDataWidth-1:0] pattern_high_q;

	bps_pkg::push_t push;
	logic           queue_full;
	logic           head_valid;
	bps_pkg::job_t  head;
	logic           pop;

	assign cfg_ready = 1'b1;

	// Configuration registers; writes to unknown indexes are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pattern_length_q <= bps_pkg::LenWidth'(1);
			pattern_low_q    <= '0;
			pattern_high_q   <= '0;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				bps_pkg::CfgPatternLength: pattern_length_q <= cfg_data[bps_pkg::LenWidth-1:0];
				bps_pkg::CfgPatternLow:    pattern_low_q    <= cfg_data;
				bps_pkg::CfgPatternHigh:   pattern_high_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	bps_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.src_valid      (src_valid),
		.src_ready      (src_ready),
		.src_item       (src_item),
		.pattern_length (pattern_length_q),
		.queue_full     (queue_full),
		.push           (push)
	);

	bps_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (queue_full),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop)
	);

	bps_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head       (head),
		.pop        (pop),
		.pattern    ({pattern_high_q, pattern_low_q}),
		.res_valid  (res_valid),
		.res_ready  (res_ready),
		.res_item   (res_item)
	);

endmodule

@@ test/bijective_pattern_search_unit_checker.sv @@
// Scoreboard for the bijective pattern search unit: predicts each match and checks every result.
`timescale 1ns / 1ps

module bijective_pattern_search_unit_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               src_valid,
	input  logic                               src_ready,
	input  bps_pkg::in_item_t                  src_item,
	input  logic                               res_valid,
	input  logic                               res_ready,
	input  bps_pkg::out_item_t                 res_item,
	input  logic                               cfg_valid,
	input  logic                               cfg_ready,
	input  logic [bps_pkg::CfgIndexWidth-1:0]  cfg_index,
	input  logic [bps_pkg::CfgDataWidth-1:0]   cfg_data,
	output int                                 failures,
	output int                                 outstanding,
	output int                                 matches_seen
);
	import bps_pkg::*;

	// Model state: the symbol history (entry 0 newest), the count since the last mark
	// and a copy of the three registers.
	sym_t                    history [PatternMax];
	logic [CountWidth-1:0]   since_mark;
	logic [LenWidth-1:0]     length_reg;
	logic [PatternWidth-1:0] pattern_reg;
	out_item_t               expected_matches [$];

	// Prints one line per mismatch and counts it; printing stops after a hundred lines.
	task automatic report_mismatch(input string what);
		if (failures < 100) begin
			$display("[%0t] mismatch: %s", $time, what);
		end
		failures++;
	endtask

	// Shifts one source symbol in and, when a window completes and a one-to-one mapping
	// onto the pattern exists, queues the match that the block must report.
	task automatic shift_and_match(input in_item_t item);
		int                   eff;
		int                   j;
		sym_t                 s;
		sym_t                 p;
		logic [SymValues-1:0] src_used;
		logic [SymValues-1:0] pat_used;
		sym_t                 to_pattern [SymValues];
		bit                   ok;
		out_item_t            found;

		if (item.new_source) begin
			since_mark = '0;
		end
		for (j = PatternMax - 1; j > 0; j--) begin
			history[j] = history[j-1];
		end
		history[0] = item.symbol;
		if (since_mark != '1) begin
			since_mark++;
		end

		// A length of zero acts as one; anything past the window size is clipped.
		if (length_reg == '0) begin
			eff = 1;
		end else if (length_reg > PatternMax) begin
			eff = PatternMax;
		end else begin
			eff = int'(length_reg);
		end
		if (since_mark < CountWidth'(eff)) begin
			return;
		end

		// Walk the oldest window symbol against pattern symbol 0 upward.
		src_used = '0;
		pat_used = '0;
		ok = 1'b1;
		for (j = 0; j < SymValues; j++) begin
			to_pattern[j] = '0;
		end
		for (j = 0; j < eff && ok; j++) begin
			s = history[eff-1-j];
			p = pattern_reg[j*SymbolBits +: SymbolBits];
			if (src_used[s]) begin
				if (to_pattern[s] != p) begin
					ok = 1'b0;
				end
			end else if (!pat_used[p]) begin
				src_used[s] = 1'b1;
				pat_used[p] = 1'b1;
				to_pattern[s] = p;
			end else begin
				ok = 1'b0;
			end
		end
		if (!ok) begin
			return;
		end

		// Unmapped source values read as zero in the packed mapping.
		found.match_start = since_mark - CountWidth'(eff);
		found.mapping_packed = '0;
		for (j = 0; j < SymValues; j++) begin
			if (src_used[j]) begin
				found.mapping_packed[j*SymbolBits +: SymbolBits] = to_pattern[j];
			end
		end
		found.mapped_mask = src_used;
		expected_matches.insert(expected_matches.size(), found);
	endtask

	// Watch all three channels at each rising edge.
	always @(posedge clk or negedge arst_n) begin
		out_item_t want;
		if (!arst_n) begin
			for (int j = 0; j < PatternMax; j++) begin
				history[j] = '0;
			end
			since_mark = '0;
			length_reg = LenWidth'(1);
			pattern_reg = '0;
			expected_matches.delete();
			failures = 0;
			outstanding = 0;
			matches_seen = 0;
		end else begin
			// Results are compared before this edge's source transfer is predicted.
			if (res_valid && res_ready) begin
				matches_seen++;
				if (expected_matches.size() == 0) begin
					report_mismatch($sformatf("result at start %0d with no match expected",
						res_item.match_start));
				end else begin
					want = expected_matches.pop_front();
					if (res_item.match_start != want.match_start) begin
						report_mismatch($sformatf("match_start %0d, expected %0d",
							res_item.match_start, want.match_start));
					end
					if (res_item.mapping_packed != want.mapping_packed) begin
						report_mismatch($sformatf("mapping_packed %h, expected %h",
							res_item.mapping_packed, want.mapping_packed));
					end
					if (res_item.mapped_mask != want.mapped_mask) begin
						report_mismatch($sformatf("mapped_mask %h, expected %h",
							res_item.mapped_mask, want.mapped_mask));
					end
				end
			end

			// Register writes.
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CfgPatternLength: begin
						length_reg = cfg_data[LenWidth-1:0];
					end
					CfgPatternLow: begin
						pattern_reg[CfgDataWidth-1:0] = cfg_data;
					end
					CfgPatternHigh: begin
						pattern_reg[PatternWidth-1:CfgDataWidth] = cfg_data;
					end
					default: begin
					end
				endcase
			end

			if (src_valid && src_ready) begin
				shift_and_match(src_item);
			end
			outstanding = expected_matches.size();
		end
	end

endmodule

@@ test/bijective_pattern_search_unit_tb.sv @@
// Testbench top of the bijective pattern search unit: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module bijective_pattern_search_unit_tb;
	import bps_pkg::*;

	localparam int CycleLimit  = 1_000_000;
	localparam int PhaseItems  = 200;
	localparam int PhaseCount  = 10;
	localparam int DrainCycles = 120;

	logic                     clk = 1'b0;
	logic                     arst_n = 1'b0;
	logic                     src_valid = 1'b0;
	logic                     src_ready;
	in_item_t                 src_item = '0;
	logic                     res_valid;
	logic                     res_ready = 1'b0;
	out_item_t                res_item;
	logic                     cfg_valid = 1'b0;
	logic                     cfg_ready;
	logic [CfgIndexWidth-1:0] cfg_index = CfgPatternLength;
	logic [CfgDataWidth-1:0]  cfg_data = '0;

	int                       failures;
	int                       outstanding;
	int                       matches_seen;
	bit                       calm = 1'b0;
	int                       stall_left = 0;
	int                       cycles = 0;
	int                       symbols_sent = 0;
	int                       settings_done = 0;
	logic [PatternWidth-1:0]  cur_pattern = '0;
	int                       run_len = 1;

	bijective_pattern_search_unit u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_ready (src_ready),
		.src_item  (src_item),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.res_item  (res_item),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	bijective_pattern_search_unit_checker u_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.src_valid    (src_valid),
		.src_ready    (src_ready),
		.src_item     (src_item),
		.res_valid    (res_valid),
		.res_ready    (res_ready),
		.res_item     (res_item),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.failures     (failures),
		.outstanding  (outstanding),
		.matches_seen (matches_seen)
	);

	// 10 ns clock.
	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	// Give up when the run takes far longer than the slowest correct block would.
	always @(posedge clk) begin
		cycles++;
		if (cycles >= CycleLimit) begin
			$display("[bijective_pattern_search_unit] ERROR");
			$finish;
		end
	end

	// Result side stalls in random bursts, except in the calm stretch.
	always @(negedge clk) begin
		if (calm) begin
			res_ready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left--;
			res_ready <= 1'b0;
		end else if ($urandom_range(0, 7) == 0) begin
			stall_left = $urandom_range(0, 9);
			res_ready <= 1'b0;
		end else begin
			res_ready <= 1'b1;
		end
	end

	// One source transfer, sometimes preceded by an idle burst.
	task automatic send_symbol(input logic [3:0] sym, input logic mark);
		int gap;
		@(negedge clk);
		if (!calm && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 10);
			src_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		src_valid <= 1'b1;
		src_item <= '{symbol: sym, new_source: mark};
		@(posedge clk);
		while (!src_ready) @(posedge clk);
		symbols_sent++;
	endtask

	// One configuration register transfer.
	task automatic write_reg(input logic [CfgIndexWidth-1:0] idx,
			input logic [CfgDataWidth-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid <= 1'b0;
	endtask

	// Writes all three registers and keeps the length in use for building matching runs.
	task automatic program_pattern(input logic [LenWidth-1:0] len,
			input logic [CfgDataWidth-1:0] low, input logic [CfgDataWidth-1:0] high);
		write_reg(CfgPatternLength, CfgDataWidth'(len));
		write_reg(CfgPatternLow, low);
		write_reg(CfgPatternHigh, high);
		cur_pattern = {high, low};
		if (len == '0) begin
			run_len = 1;
		end else if (len > PatternMax) begin
			run_len = PatternMax;
		end else begin
			run_len = int'(len);
		end
		settings_done++;
	endtask

	// Drops valid, waits for every expected match, then lets windows without a match finish.
	task automatic settle();
		@(negedge clk);
		src_valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (DrainCycles) @(posedge clk);
	endtask

	initial begin
		int                      perm [SymValues];
		int                      j;
		int                      k;
		int                      tmp;
		int                      burst;
		int                      phase;
		int                      fill;
		int                      bad_at;
		bit                      broken;
		bit                      fresh;
		logic [LenWidth-1:0]     len;
		logic [CfgDataWidth-1:0] low;
		logic [CfgDataWidth-1:0] high;
		logic [PatternWidth-1:0] two_sym;
		logic [3:0]              sym_a;
		logic [3:0]              sym_b;
		logic [3:0]              sym;

		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset settings: length one, so every symbol matches; a mark restarts the position.
		send_symbol(4'h0, 1'b0);
		send_symbol(4'hF, 1'b0);
		send_symbol(4'hA, 1'b1);
		send_symbol(4'h5, 1'b0);
		settle();

		// Pattern 0,1,0: a clean match, a shifted match, a window cut short by a mark,
		// a source symbol that would need two targets, and a target used twice.
		program_pattern(LenWidth'(3), 64'h0000_0000_0000_0010, '0);
		send_symbol(4'h3, 1'b1);
		send_symbol(4'h7, 1'b0);
		send_symbol(4'h3, 1'b0);
		send_symbol(4'h7, 1'b0);
		send_symbol(4'h3, 1'b1);
		send_symbol(4'h3, 1'b0);
		send_symbol(4'h3, 1'b0);
		send_symbol(4'hC, 1'b0);
		send_symbol(4'hF, 1'b0);

		// Random phases, each under its own register setting.
		for (phase = 0; phase < PhaseCount; phase++) begin
			settle();
			if (phase == PhaseCount - 1) begin
				calm = 1'b1;
			end
			low = {$urandom, $urandom};
			high = {$urandom, $urandom};
			case (phase)
				0: len = LenWidth'(32);
				1: begin
					len = '1;
					low = '1;
				end
				2: begin
					len = '0;
					high = '0;
				end
				3: begin
					len = LenWidth'(1);
					low = '0;
					high = '1;
				end
				4: len = LenWidth'(40);
				default: len = LenWidth'($urandom_range(2, 12));
			endcase

			// A two-symbol pattern lets plain noise match now and then.
			if (phase >= 5 && phase % 2 == 1) begin
				sym_a = 4'($urandom_range(0, 15));
				sym_b = 4'($urandom_range(0, 15));
				for (j = 0; j < PatternMax; j++) begin
					two_sym[j*SymbolBits +: SymbolBits] = $urandom_range(0, 1) ? sym_b : sym_a;
				end
				{high, low} = two_sym;
			end
			program_pattern(len, low, high);

			fill = 0;
			while (fill < PhaseItems) begin
				if ($urandom_range(0, 4) != 0) begin
					// Pattern relabeled through a random permutation, sometimes with one
					// symbol spoiled.
					for (j = 0; j < SymValues; j++) begin
						perm[j] = j;
					end
					for (j = SymValues - 1; j > 0; j--) begin
						k = $urandom_range(0, j);
						tmp = perm[j];
						perm[j] = perm[k];
						perm[k] = tmp;
					end
					broken = ($urandom_range(0, 4) == 0);
					bad_at = $urandom_range(0, run_len - 1);
					fresh = ($urandom_range(0, 3) == 0);
					for (j = 0; j < run_len; j++) begin
						sym = 4'(perm[cur_pattern[j*SymbolBits +: SymbolBits]]);
						if (broken && j == bad_at) begin
							sym = 4'($urandom_range(0, 15));
						end
						send_symbol(sym, fresh && j == 0);
					end
					fill += run_len;
				end else begin
					// Noise with an occasional new source mark.
					burst = $urandom_range(1, 8);
					for (j = 0; j < burst; j++) begin
						send_symbol(4'($urandom_range(0, 15)), $urandom_range(0, 19) == 0);
					end
					fill += burst;
				end
			end
		end
		settle();

		$display("Sent %0d source symbols under %0d register settings, lengths 0 to 63.",
			symbols_sent, settings_done);
		$display("Checked %0d reported matches field by field.", matches_seen);
		if (failures == 0) begin
			$display("[bijective_pattern_search_unit] OK");
		end else begin
			$display("[bijective_pattern_search_unit] ERROR");
		end
		$finish;
	end

endmodule
